// File: rtl/pcxrle_pkg.sv
// shared types and constants of the pcx run-length scanline encoder
`default_nettype none

package pcxrle_pkg;

	localparam logic [5:0] RUN_MAX       = 6'd63;
	localparam logic [7:0] LITERAL_LIMIT = 8'd192;
	localparam logic [7:0] COUNT_MARK    = 8'hC0;
	localparam logic [7:0] FULL_RUN_CODE = 8'hFF;
	localparam int         MAX_CODES     = 4;

	typedef struct packed {
		logic [7:0] pixel;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_of_input;
		logic       line_done;
	} out_item_t;

	// codes caused by one input item, oldest in entry 0
	typedef struct packed {
		logic [MAX_CODES-1:0][7:0] codes;
		logic [2:0]                count;
		logic                      line_end;
	} code_set_t;

endpackage

`default_nettype wire

// File: rtl/pcxrle_encode.sv
// run tracking state and code generation for one pixel
`default_nettype none

module pcxrle_encode (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         accept,
	input  wire pcxrle_pkg::in_item_t   item,
	output pcxrle_pkg::code_set_t       code_set
);

	logic [7:0] run_value_q;
	logic [5:0] run_length_q;
	logic       line_open_q;

	logic [7:0] nxt_value;
	logic [5:0] nxt_length;
	logic [5:0] inc_length;
	logic [2:0] n;
	logic [3:0][7:0] codes;

	always_comb begin
		codes      = '0;
		n          = 3'd0;
		nxt_value  = run_value_q;
		nxt_length = run_length_q;
		inc_length = run_length_q + 6'd1;

		if (!line_open_q) begin
			nxt_value  = item.pixel;
			nxt_length = 6'd1;
		end else if (item.pixel == run_value_q) begin
			if (inc_length == pcxrle_pkg::RUN_MAX) begin
				codes[n[1:0]] = pcxrle_pkg::FULL_RUN_CODE;
				n = n + 3'd1;
				codes[n[1:0]] = item.pixel;
				n = n + 3'd1;
				nxt_length = 6'd0;
			end else begin
				nxt_length = inc_length;
			end
		end else begin
			// close the run that the new pixel breaks
			if (run_length_q != 6'd0) begin
				if (run_length_q == 6'd1 && run_value_q < pcxrle_pkg::LITERAL_LIMIT) begin
					codes[n[1:0]] = run_value_q;
					n = n + 3'd1;
				end else begin
					codes[n[1:0]] = pcxrle_pkg::COUNT_MARK | {2'b00, run_length_q};
					n = n + 3'd1;
					codes[n[1:0]] = run_value_q;
					n = n + 3'd1;
				end
			end
			nxt_value  = item.pixel;
			nxt_length = 6'd1;
		end

		// flush at end of scanline
		if (item.line_end && nxt_length != 6'd0) begin
			if (nxt_length == 6'd1 && nxt_value < pcxrle_pkg::LITERAL_LIMIT) begin
				codes[n[1:0]] = nxt_value;
				n = n + 3'd1;
			end else begin
				codes[n[1:0]] = pcxrle_pkg::COUNT_MARK | {2'b00, nxt_length};
				n = n + 3'd1;
				codes[n[1:0]] = nxt_value;
				n = n + 3'd1;
			end
		end

		code_set.codes    = codes;
		code_set.count    = n;
		code_set.line_end = item.line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= 8'd0;
			run_length_q <= 6'd0;
			line_open_q  <= 1'b0;
		end else if (accept) begin
			if (item.line_end) begin
				run_value_q  <= 8'd0;
				run_length_q <= 6'd0;
				line_open_q  <= 1'b0;
			end else begin
				run_value_q  <= nxt_value;
				run_length_q <= nxt_length;
				line_open_q  <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pcxrle_serial.sv
// code slot and output register, one code byte per transfer
`default_nettype none

module pcxrle_serial (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         load,
	input  wire pcxrle_pkg::code_set_t  code_set,
	output logic                        slot_free,
	output logic                        out_valid,
	input  wire                         out_ready,
	output pcxrle_pkg::out_item_t       out_data
);

	pcxrle_pkg::code_set_t slot_s1;
	logic                  slot_valid_s1;
	logic [1:0]            idx_q;
	pcxrle_pkg::out_item_t out_s2;
	logic                  out_valid_s2;

	logic move;
	logic slot_last;

	assign move      = slot_valid_s1 && (!out_valid_s2 || out_ready);
	assign slot_last = ({1'b0, idx_q} + 3'd1) == slot_s1.count;
	assign slot_free = !slot_valid_s1 || (move && slot_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_s1 <= 1'b0;
			idx_q         <= 2'd0;
		end else if (load) begin
			slot_valid_s1 <= 1'b1;
			idx_q         <= 2'd0;
		end else if (move && slot_last) begin
			slot_valid_s1 <= 1'b0;
		end else if (move) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_s1 <= code_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (move) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_s2.code_byte     <= slot_s1.codes[idx_q];
			out_s2.last_of_input <= slot_last;
			out_s2.line_done     <= slot_last && slot_s1.line_end;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_s2;

endmodule

`default_nettype wire

// File: rtl/pcx_rle_scanline_encoder.sv
// pcx run-length scanline encoder: one pixel in, zero to four code bytes out
// output: the codes of a pixel are registered in the code slot, then moved one by one into the output register
// throughput: one pixel per cycle while the code slot is free; else the next pixel waits until the slot moves
//   its last code byte into the single byte-wide output register
// reset: arst_n clears run state, the code slot and the output register
`default_nettype none

module pcx_rle_scanline_encoder (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire pcxrle_pkg::in_item_t   in_data,
	output logic                        out_valid,
	input  wire                         out_ready,
	output pcxrle_pkg::out_item_t       out_data
);

	// input transfer and the codes it causes
	logic                  accept;
	logic                  slot_free;
	pcxrle_pkg::code_set_t code_set;

	// a pixel is taken whenever the slot is empty or drains this cycle,
	// so a finished code may still wait on the output while the next pixel enters
	assign in_ready = slot_free;
	assign accept   = in_valid && in_ready;

	// run state lives here; codes come out combinationally from state and pixel
	pcxrle_encode u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (in_data),
		.code_set (code_set)
	);

	// pixels that only extend a run load nothing into the slot
	pcxrle_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && code_set.count != 3'd0),
		.code_set  (code_set),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// end of line always flushes at least one code
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.line_end) |-> (code_set.count != 3'd0))
		else $error("line end transfer produced no code");

	// never more codes than the slot holds
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (code_set.count <= 3'd4))
		else $error("code count exceeds slot depth");

	// line_done only on the last code of its input
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.line_done) |-> out_data.last_of_input)
		else $error("line_done without last_of_input");

endmodule

`default_nettype wire

// File: dv/pcx_rle_checker.sv
// checker: predicts the code bytes of each accepted pixel and compares them with the output
module pcx_rle_checker (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    in_ready,
	input  pcxrle_pkg::in_item_t   in_data,
	input  wire                    out_valid,
	input  wire                    out_ready,
	input  pcxrle_pkg::out_item_t  out_data,
	output int                     mismatches,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// predictor state
	logic [7:0] cur_pixel;
	logic [5:0] cur_count;
	logic       in_line;

	logic [7:0]            new_codes[$];
	pcxrle_pkg::out_item_t expected_codes[$];
	pcxrle_pkg::out_item_t want;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: mismatch, %s", $time, what);
	endtask

	// close the pending run into new_codes
	function automatic void flush_run();
		if (cur_count == 6'd0)
			return;
		if (cur_count == 6'd1 && cur_pixel < pcxrle_pkg::LITERAL_LIMIT) begin
			new_codes.push_back(cur_pixel);
		end else begin
			new_codes.push_back(pcxrle_pkg::COUNT_MARK | {2'b00, cur_count});
			new_codes.push_back(cur_pixel);
		end
	endfunction

	function automatic void encode_pixel(input pcxrle_pkg::in_item_t item);
		pcxrle_pkg::out_item_t code;
		new_codes.delete();
		if (!in_line) begin
			cur_pixel = item.pixel;
			cur_count = 6'd1;
			in_line   = 1'b1;
		end else if (item.pixel == cur_pixel) begin
			cur_count = cur_count + 6'd1;
			if (cur_count == pcxrle_pkg::RUN_MAX) begin
				new_codes.push_back(pcxrle_pkg::FULL_RUN_CODE);
				new_codes.push_back(item.pixel);
				cur_count = 6'd0;
			end
		end else begin
			flush_run();
			cur_pixel = item.pixel;
			cur_count = 6'd1;
		end
		if (item.line_end) begin
			flush_run();
			cur_pixel = 8'd0;
			cur_count = 6'd0;
			in_line   = 1'b0;
		end
		foreach (new_codes[i]) begin
			code.code_byte     = new_codes[i];
			code.last_of_input = (i == new_codes.size() - 1);
			code.line_done     = code.last_of_input && item.line_end;
			expected_codes.push_back(code);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pixel = 8'd0;
			cur_count = 6'd0;
			in_line   = 1'b0;
			expected_codes.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				encode_pixel(in_data);
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					report_mismatch($sformatf("code %h with nothing expected",
						out_data.code_byte));
				end else begin
					want = expected_codes.pop_front();
					if (out_data.code_byte !== want.code_byte)
						report_mismatch($sformatf("code_byte got %h want %h",
							out_data.code_byte, want.code_byte));
					if (out_data.last_of_input !== want.last_of_input)
						report_mismatch($sformatf("last_of_input got %b want %b on code %h",
							out_data.last_of_input, want.last_of_input, want.code_byte));
					if (out_data.line_done !== want.line_done)
						report_mismatch($sformatf("line_done got %b want %b on code %h",
							out_data.line_done, want.line_done, want.code_byte));
				end
			end
			pending <= expected_codes.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// testbench top: feeds pixel lines to the run-length encoder and reports the verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// short hand-picked lines: literals, count bytes, the 191/192 border,
	// one-pixel lines, four codes from one pixel, pixels that only extend a run
	localparam pcxrle_pkg::in_item_t DIRECTED [18] = '{
		{8'h00, 1'b1}, {8'hFF, 1'b1}, {8'd191, 1'b1}, {8'd192, 1'b1},
		{8'h05, 1'b0}, {8'h05, 1'b0}, {8'hC8, 1'b1},
		{8'hC8, 1'b0}, {8'h07, 1'b0}, {8'h07, 1'b1},
		{8'h55, 1'b0}, {8'hAA, 1'b1},
		{8'h09, 1'b0}, {8'h09, 1'b0}, {8'h09, 1'b0}, {8'h09, 1'b1},
		{8'd192, 1'b0}, {8'd192, 1'b1}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pcxrle_pkg::in_item_t  in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	pcxrle_pkg::out_item_t out_data;
	int                    mismatches;
	int                    pending;

	// idle rates in percent, changed per phase
	int send_idle_pct = 25;
	int recv_stall_pct = 77;
	int items_sent = 0;

	always #5 clk = ~clk;

	pcx_rle_scanline_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	pcx_rle_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver stalls at random, at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// hard stop in case the encoder hangs
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// one pixel transfer, preceded by random idle cycles
	task automatic send_pixel(input pcxrle_pkg::in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		// valid holds with the same payload until the transfer happens
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// sender holds off until every predicted code byte has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// pixel values biased toward repeats and the literal border
	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'($urandom_range(255));
			4, 5, 6:    return 8'($urandom_range(191, 192));
			default:    return 8'($urandom_range(3));
		endcase
	endfunction

	// mostly short runs, some around the 63 limit, some two full runs
	function automatic int pick_length();
		case ($urandom_range(29))
			0:       return 63;
			1:       return 126;
			2:       return $urandom_range(60, 66);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	// a well-formed scanline: a few runs, line_end on the last pixel
	task automatic send_line();
		int runs;
		int len;
		logic [7:0] val;
		runs = $urandom_range(1, 5);
		for (int r = 0; r < runs; r++) begin
			val = pick_pixel();
			len = pick_length();
			for (int k = 0; k < len; k++)
				send_pixel({val, (r == runs - 1) && (k == len - 1)});
		end
	endtask

	initial begin
		// reset once at the start, then released
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_pixel(DIRECTED[i]);
		drain();

		// phase 0: sender idles lightly, receiver stalls heavily
		// phase 1: the other way round; phase 2: no idling at all
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 77 : 0;
			recv_stall_pct = (ph == 0) ? 77 : (ph == 1) ? 25 : 0;
			while (items_sent < 150 + ph * 160) begin
				// one pick in ten is noise: any pixel, any line_end
				if ($urandom_range(9) == 0)
					send_pixel(pcxrle_pkg::in_item_t'(9'($urandom_range(511))));
				else
					send_line();
			end
			drain();
		end

		// let anything stray still show up
		repeat (10) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/pcxrle_pkg.sv
rtl/pcxrle_encode.sv
rtl/pcxrle_serial.sv
rtl/pcx_rle_scanline_encoder.sv
dv/pcx_rle_checker.sv
dv/tb_top.sv
